[hdl/polynomial_multiply_accumulate_defines.svh]
// ---------------------------------------------------------------------------
// polynomial multiply accumulate assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define POLYNOMIAL_MULTIPLY_ACCUMULATE_DEFINES_SVH

// same-cycle implication
`define PMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pma_pkg.sv]
// ---------------------------------------------------------------------------
// pma_pkg
// shared types and constants of the polynomial multiply accumulate block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pma_pkg;

  // fixed field widths
  localparam int CMD_W       = 2;
  localparam int TERM_COEF_W = 16;
  localparam int TERM_EXP_W  = 4;
  localparam int PROD_COEF_W = 40;
  localparam int PROD_EXP_W  = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  // input transaction kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A   = 2'd0,
    CMD_LOAD_B   = 2'd1,
    CMD_MULTIPLY = 2'd2
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic acc_clr;
    logic row_clr;
    logic mul_en;
    logic nz_capture;
    logic scan_init;
    logic scan_step;
    logic out_load;
    logic out_empty;
    logic clear_all;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_last;
    logic scan_done;
    logic nz_here;
    logic any_nz;
    logic out_free;
    logic both_loaded;
  } dp_sts_t;

endpackage

[hdl/pma_datapath.sv]
// ---------------------------------------------------------------------------
// pma_datapath
// coefficient stores, multiplier row, product accumulators and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pma_datapath
  import pma_pkg::*;
#(
  parameter int MAX_EXPONENTS = 16,
  parameter int COEFF_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd_i,
  output dp_sts_t                       sts_o,
  input  logic signed [TERM_COEF_W-1:0] term_coef_i,
  input  logic [TERM_EXP_W-1:0]         term_exp_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [PROD_COEF_W-1:0]        out_coef_o,
  output logic [PROD_EXP_W-1:0]         out_exp_o,
  output logic                          out_term_valid_o,
  output logic                          out_last_o
);

  localparam int SB = COEFF_BITS + 4;
  localparam int PB = 2 * SB;
  localparam int PD = 2 * MAX_EXPONENTS - 1;
  localparam int EW = (MAX_EXPONENTS > 1) ? $clog2(MAX_EXPONENTS) : 1;
  localparam int KW = $clog2(PD);

  logic signed [SB-1:0] a_r [MAX_EXPONENTS];
  logic signed [SB-1:0] b_r [MAX_EXPONENTS];
  logic [1:0]           loaded_r;
  logic [EW-1:0]        row_r;
  logic [EW-1:0]        prow_r;
  logic                 pvalid_r;
  logic signed [PB-1:0] prod_r [MAX_EXPONENTS];
  logic signed [PB-1:0] acc_r [PD];
  logic [PD-1:0]        nz_r;
  logic [KW-1:0]        scan_r;

  logic                   out_valid_r;
  logic [PROD_COEF_W-1:0] out_coef_r;
  logic [PROD_EXP_W-1:0]  out_exp_r;
  logic                   out_tv_r;
  logic                   out_last_r;

  logic signed [COEFF_BITS-1:0] coef_trunc;
  logic signed [SB-1:0]         coef_ext;
  logic [EW-1:0]                ex_idx;
  logic                         in_range;
  logic signed [SB-1:0]         a_rd;
  logic signed [SB-1:0]         a_sum;
  logic signed [SB-1:0]         b_sum;
  logic signed [PB-1:0]         addend [PD];
  logic [PD-1:0]                below_mask;
  logic                         nz_below;
  logic                         out_free;

  // term coefficient taken as a COEFF_BITS two's-complement value
  assign coef_trunc = COEFF_BITS'(term_coef_i);
  assign coef_ext   = SB'(coef_trunc);
  assign ex_idx     = EW'(term_exp_i);
  assign in_range   = int'(term_exp_i) < MAX_EXPONENTS;

  // one read port on the first store, shared by loads and the multiply rows
  assign a_rd  = (cmd_i.load_a) ? a_r[ex_idx] : a_r[row_r];
  assign a_sum = a_rd + coef_ext;
  assign b_sum = b_r[ex_idx] + coef_ext;

  // route each product of the current row onto its summed exponent
  always_comb begin
    for (int k = 0; k < PD; k++) begin
      addend[k] = '0;
      for (int j = 0; j < MAX_EXPONENTS; j++) begin
        if (int'(prow_r) + j == k) begin
          addend[k] = prod_r[j];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < PD; k++) begin
      below_mask[k] = k < int'(scan_r);
    end
  end

  assign nz_below = |(nz_r & below_mask);
  assign out_free = !out_valid_r || out_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_EXPONENTS; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
      end
      loaded_r <= '0;
    end else if (cmd_i.clear_all) begin
      for (int i = 0; i < MAX_EXPONENTS; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
      end
      loaded_r <= '0;
    end else begin
      if (cmd_i.load_a && in_range) begin
        a_r[ex_idx] <= a_sum;
        loaded_r[0] <= 1'b1;
      end
      if (cmd_i.load_b && in_range) begin
        b_r[ex_idx] <= b_sum;
        loaded_r[1] <= 1'b1;
      end
    end
  end

  // multiplier row: one stored coefficient of the first operand against all
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      prow_r   <= '0;
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= cmd_i.mul_en;
      if (cmd_i.row_clr) begin
        row_r <= '0;
      end else if (cmd_i.mul_en) begin
        row_r  <= row_r + 1'b1;
        prow_r <= row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.mul_en) begin
      for (int j = 0; j < MAX_EXPONENTS; j++) begin
        prod_r[j] <= a_rd * b_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PD; k++) begin
        acc_r[k] <= '0;
      end
    end else if (cmd_i.acc_clr || cmd_i.clear_all) begin
      for (int k = 0; k < PD; k++) begin
        acc_r[k] <= '0;
      end
    end else if (pvalid_r) begin
      for (int k = 0; k < PD; k++) begin
        acc_r[k] <= acc_r[k] + addend[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r   <= '0;
      scan_r <= '0;
    end else begin
      if (cmd_i.clear_all) begin
        nz_r <= '0;
      end else if (cmd_i.nz_capture) begin
        for (int k = 0; k < PD; k++) begin
          nz_r[k] <= acc_r[k] != '0;
        end
      end
      if (cmd_i.scan_init) begin
        scan_r <= KW'(PD - 1);
      end else if (cmd_i.scan_step) begin
        scan_r <= scan_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_coef_r <= PROD_COEF_W'(acc_r[scan_r]);
      out_exp_r  <= PROD_EXP_W'(scan_r);
      out_tv_r   <= 1'b1;
      out_last_r <= !nz_below;
    end else if (cmd_i.out_empty) begin
      out_coef_r <= '0;
      out_exp_r  <= '0;
      out_tv_r   <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign sts_o.row_last    = row_r == EW'(MAX_EXPONENTS - 1);
  assign sts_o.scan_done   = scan_r == '0;
  assign sts_o.nz_here     = nz_r[scan_r];
  assign sts_o.any_nz      = |nz_r;
  assign sts_o.out_free    = out_free;
  assign sts_o.both_loaded = &loaded_r;

  assign out_valid_o      = out_valid_r;
  assign out_coef_o       = out_coef_r;
  assign out_exp_o        = out_exp_r;
  assign out_term_valid_o = out_tv_r;
  assign out_last_o       = out_last_r;

endmodule

[hdl/pma_ctrl.sv]
// ---------------------------------------------------------------------------
// pma_ctrl
// sequencer for loads, multiply rows, accumulator scan and clearing
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polynomial_multiply_accumulate_defines.svh"

module pma_ctrl
  import pma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_tready,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_FLAG,
    S_SCAN,
    S_DONE
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  dp_cmd_t ctl;

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            CMD_LOAD_A: ctl.load_a = 1'b1;
            CMD_LOAD_B: ctl.load_b = 1'b1;
            CMD_MULTIPLY: begin
              // with an operand never loaded the product is empty
              if (sts_i.both_loaded) begin
                ctl.acc_clr = 1'b1;
                ctl.row_clr = 1'b1;
                state_nxt   = S_MUL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
        if (sts_i.row_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = S_FLAG;
      end
      S_FLAG: begin
        ctl.nz_capture = 1'b1;
        ctl.scan_init  = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (!sts_i.any_nz) begin
          if (sts_i.out_free) begin
            ctl.out_empty = 1'b1;
            state_nxt     = S_DONE;
          end
        end else if (!sts_i.nz_here || sts_i.out_free) begin
          ctl.out_load = sts_i.nz_here;
          if (sts_i.scan_done) begin
            state_nxt = S_DONE;
          end else begin
            ctl.scan_step = 1'b1;
          end
        end
      end
      S_DONE: begin
        ctl.clear_all = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd_o = ctl;

  `PMA_ASSERT_SAME(a_load_needs_room, ctl.out_load || ctl.out_empty, sts_i.out_free, "output register overwritten")
  `PMA_ASSERT_SAME(a_one_out_source, ctl.out_load, !ctl.out_empty, "term and empty marker together")
  `PMA_ASSERT_NEXT(a_clear_drops_flags, ctl.clear_all, !sts_i.any_nz && !sts_i.both_loaded, "stale state after clear")
  `PMA_ASSERT_SAME(a_scan_single_step, ctl.scan_step, !ctl.scan_init, "scan pointer double drive")

endmodule

[hdl/polynomial_multiply_accumulate.sv]
// A load transaction (tuser load A or load B) adds its coefficient into the dense store of
// that operand at its exponent; a multiply transaction runs one row of MAX_EXPONENTS
// multipliers per cycle over each of the first operand's terms, passes through the S_ACC and
// S_FLAG states for the last accumulate and the nonzero flags, then scans the
// 2*MAX_EXPONENTS-1 accumulators from the top exponent down at one per cycle unless the
// output stalls on a nonzero term, emitting each nonzero term and marking the last, and
// clears the stores in S_DONE; a multiply keeps the input closed throughout, including any
// output stall, and skips the multiplier row when an operand was never loaded. An empty or
// all-zero product gives one transaction with tuser clear and tlast set. All stores clear
// afterwards.
// ---------------------------------------------------------------------------
// polynomial_multiply_accumulate
// sparse term loader and dense polynomial multiplier with descending term output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module polynomial_multiply_accumulate
  import pma_pkg::*;
#(
  parameter int MAX_EXPONENTS = 16,
  parameter int COEFF_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // term_coefficient[15:0], term_exponent[19:16]
  input  logic [CMD_W-1:0]       in_tuser,   // cmd[1:0]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // product_coefficient[39:0], product_exponent[44:40]
  output logic [0:0]             out_tuser,  // term_valid[0]
  output logic                   out_tlast   // last_term
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  logic signed [TERM_COEF_W-1:0] term_coef;
  logic [TERM_EXP_W-1:0]         term_exp;
  logic [PROD_COEF_W-1:0]        prod_coef;
  logic [PROD_EXP_W-1:0]         prod_exp;
  logic                          term_valid;

  // unpack the input transaction
  assign term_coef = in_tdata[TERM_COEF_W-1:0];
  assign term_exp  = in_tdata[TERM_COEF_W +: TERM_EXP_W];

  // sequencer: accepts transactions only while idle
  pma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  // stores, multiplier row, accumulators and output register
  pma_datapath #(
    .MAX_EXPONENTS (MAX_EXPONENTS),
    .COEFF_BITS    (COEFF_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .term_coef_i      (term_coef),
    .term_exp_i       (term_exp),
    .out_ready_i      (out_tready),
    .out_valid_o      (out_tvalid),
    .out_coef_o       (prod_coef),
    .out_exp_o        (prod_exp),
    .out_term_valid_o (term_valid),
    .out_last_o       (out_tlast)
  );

  // pack the result transaction, zero fill to whole bytes
  assign out_tdata = {{(OUT_TDATA_W - PROD_COEF_W - PROD_EXP_W){1'b0}}, prod_exp, prod_coef};
  assign out_tuser = term_valid;

endmodule
